>>> rtl/core/lfpd_pkg.sv
// package for the line follower pid drive block
// holds request types, register indexes and reset values; no dependencies
`timescale 1ns / 1ps

package lfpd_pkg;

	localparam int POS_W   = 10;
	localparam int GAIN_W  = 24;
	localparam int PWM_W   = 10;
	localparam int STEP_W  = 7;
	localparam int TICK_W  = 16;
	localparam int ERR_W   = 11;
	localparam int DERR_W  = 12;
	localparam int SUM_W   = 25;
	localparam int CIDX_W  = 4;
	localparam int CDATA_W = 24;

	// register reset values
	localparam logic [POS_W-1:0]  CENTER_RST = 10'd250;
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd655360;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd655;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd4587520;
	localparam logic [PWM_W-1:0]  START_RST  = 10'd200;
	localparam logic [PWM_W-1:0]  MAX_RST    = 10'd600;
	localparam logic [STEP_W-1:0] STEP_RST   = 7'd1;
	localparam logic [TICK_W-1:0] TICKS_RST  = 16'd2500;

	// register index codes
	typedef enum logic [CIDX_W-1:0] {
		REG_CENTER = 4'd0,
		REG_GAIN_P = 4'd1,
		REG_GAIN_I = 4'd2,
		REG_GAIN_D = 4'd3,
		REG_START  = 4'd4,
		REG_MAX    = 4'd5,
		REG_STEP   = 4'd6,
		REG_TICKS  = 4'd7
	} cfg_reg_t;

	// sample request
	typedef struct packed {
		logic             line_seen;
		logic [POS_W-1:0] position;
	} sample_t;

	// drive request
	typedef struct packed {
		logic [PWM_W-1:0] left_drive;
		logic [PWM_W-1:0] right_drive;
		logic             run_done;
	} drive_t;

endpackage

>>> rtl/core/line_follow_pid_drive.sv
// pid steering for a differential drive line follower, three register stages
// an accepted sample goes through stage 1, stage 2 and the output register to its drive request
// throughput: one sample per cycle when not stalled; the state update sits in the first stage
// the three gain multipliers are registered before the sum, floor and clamp stage
// reset: arst_n clears pipeline valids and loads configuration and state with their reset values
// depends on lfpd_pkg
`timescale 1ns / 1ps

module line_follow_pid_drive import lfpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  sample_t             sample,
	output logic                drive_valid,
	input  logic                drive_stall,
	output drive_t              drive,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CDATA_W-1:0]  cfg_data
);

	localparam int PP_W   = ERR_W + GAIN_W + 1;
	localparam int PI_W   = SUM_W + GAIN_W + 1;
	localparam int PD_W   = DERR_W + GAIN_W + 1;
	localparam int ACC_W  = PI_W + 2;
	localparam int CORR_W = ACC_W - 16;

	// configuration registers; start drive only loads the base drive before the first tick
	logic [POS_W-1:0]  center_q;
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [PWM_W-1:0]  max_q;
	logic [STEP_W-1:0] step_q;
	logic [TICK_W-1:0] ticks_q;

	// control state
	logic [POS_W-1:0]         last_pos_q;
	logic signed [ERR_W-1:0]  last_err_q;
	logic signed [SUM_W-1:0]  err_sum_q;
	logic [PWM_W-1:0]         base_q;
	logic [TICK_W-1:0]        tick_q;

	// stage registers
	logic                     v_s1, v_s2;
	logic                     done_s1, done_s2;
	logic signed [ERR_W-1:0]  err_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic signed [DERR_W-1:0] derr_s1;
	logic [PWM_W-1:0]         base_s1, base_s2;
	logic signed [PP_W-1:0]   pp_s2;
	logic signed [PI_W-1:0]   pi_s2;
	logic signed [PD_W-1:0]   pd_s2;
	logic                     out_v_q;
	drive_t                   out_q;

	// stage enables, each stage moves when the next one has room
	logic en_out, en_s2, en_s1, accept, run_over;
	assign en_out       = !out_v_q || !drive_stall;
	assign en_s2        = !v_s2 || en_out;
	assign en_s1        = !v_s1 || en_s2;
	assign sample_stall = !en_s1;
	assign accept       = sample_valid && en_s1;
	assign cfg_ready    = 1'b1;
	assign run_over     = (tick_q >= ticks_q);

	// error, saturated integral and derivative for the accepted sample
	logic [POS_W-1:0]         pos_c;
	logic signed [ERR_W-1:0]  err_c;
	logic signed [SUM_W:0]    sum_raw_c;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [DERR_W-1:0] derr_c;
	always_comb begin
		pos_c     = sample.line_seen ? sample.position : last_pos_q;
		err_c     = $signed({1'b0, pos_c}) - $signed({1'b0, center_q});
		sum_raw_c = {err_sum_q[SUM_W-1], err_sum_q} + {{(SUM_W+1-ERR_W){err_c[ERR_W-1]}}, err_c};
		if (sum_raw_c[SUM_W] != sum_raw_c[SUM_W-1]) begin
			sum_c = sum_raw_c[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_c = sum_raw_c[SUM_W-1:0];
		end
		derr_c = {err_c[ERR_W-1], err_c} - {last_err_q[ERR_W-1], last_err_q};
	end

	// base drive ramp toward the ceiling
	logic [PWM_W:0]   ramp_sum_c;
	logic [PWM_W-1:0] base_next_c;
	always_comb begin
		ramp_sum_c = {1'b0, base_q} + {{(PWM_W+1-STEP_W){1'b0}}, step_q};
		if (base_q >= max_q) begin
			base_next_c = base_q;
		end else if (ramp_sum_c > {1'b0, max_q}) begin
			base_next_c = max_q;
		end else begin
			base_next_c = ramp_sum_c[PWM_W-1:0];
		end
	end

	// configuration writes and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q   <= CENTER_RST;
			gain_p_q   <= GAIN_P_RST;
			gain_i_q   <= GAIN_I_RST;
			gain_d_q   <= GAIN_D_RST;
			max_q      <= MAX_RST;
			step_q     <= STEP_RST;
			ticks_q    <= TICKS_RST;
			last_pos_q <= CENTER_RST;
			last_err_q <= '0;
			err_sum_q  <= '0;
			base_q     <= START_RST;
			tick_q     <= '0;
		end else begin
			if (accept && !run_over) begin
				last_pos_q <= pos_c;
				last_err_q <= err_c;
				err_sum_q  <= sum_c;
				base_q     <= base_next_c;
				tick_q     <= tick_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_CENTER: begin
						center_q <= cfg_data[POS_W-1:0];
						if (tick_q == '0) last_pos_q <= cfg_data[POS_W-1:0];
					end
					REG_GAIN_P: gain_p_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_I: gain_i_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_D: gain_d_q <= cfg_data[GAIN_W-1:0];
					REG_START: begin
						if (tick_q == '0) base_q <= cfg_data[PWM_W-1:0];
					end
					REG_MAX:   max_q   <= cfg_data[PWM_W-1:0];
					REG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
					REG_TICKS: ticks_q <= cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// stage 1: error terms and base drive of the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1 <= run_over;
			err_s1  <= err_c;
			sum_s1  <= sum_c;
			derr_s1 <= derr_c;
			base_s1 <= base_q;
		end
	end

	// stage 2: gain products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			done_s2 <= done_s1;
			base_s2 <= base_s1;
			pp_s2   <= err_s1 * $signed({1'b0, gain_p_q});
			pi_s2   <= sum_s1 * $signed({1'b0, gain_i_q});
			pd_s2   <= derr_s1 * $signed({1'b0, gain_d_q});
		end
	end

	// stage 3: sum, floor to whole units, clamp and split left and right, or zero drives on a finished run
	logic signed [ACC_W-1:0]  acc_c;
	logic signed [CORR_W-1:0] corr_c, base_ext_c;
	drive_t                   drv_c;
	always_comb begin
		acc_c = {{(ACC_W-PP_W){pp_s2[PP_W-1]}}, pp_s2}
		      + {{(ACC_W-PI_W){pi_s2[PI_W-1]}}, pi_s2}
		      + {{(ACC_W-PD_W){pd_s2[PD_W-1]}}, pd_s2};
		corr_c     = acc_c[ACC_W-1:16];
		base_ext_c = $signed({{(CORR_W-PWM_W){1'b0}}, base_s2});
		if (corr_c > base_ext_c) begin
			corr_c = base_ext_c;
		end else if (corr_c < -base_ext_c) begin
			corr_c = -base_ext_c;
		end
		if (done_s2) begin
			drv_c.left_drive  = '0;
			drv_c.right_drive = '0;
			drv_c.run_done    = 1'b1;
		end else if (corr_c < 0) begin
			drv_c.left_drive  = base_s2 + corr_c[PWM_W-1:0];
			drv_c.right_drive = base_s2;
			drv_c.run_done    = 1'b0;
		end else begin
			drv_c.left_drive  = base_s2;
			drv_c.right_drive = base_s2 - corr_c[PWM_W-1:0];
			drv_c.run_done    = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_q <= drv_c;
		end
	end

	assign drive_valid = out_v_q;
	assign drive       = out_q;

	// a finished run keeps the tick count
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && run_over |=> $stable(tick_q))
		else $error("tick count moved after the run finished");

	// a stopped drive request carries zero drives
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive.run_done |-> drive.left_drive == '0 && drive.right_drive == '0)
		else $error("drives not zero on a finished run");

	// input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v_s1 && v_s2 && drive_valid && drive_stall)
		else $error("input stalled with room in the pipeline");

endmodule

>>> tb/line_follow_pid_drive_tb.sv
// testbench for the line follower pid drive block: directed table, random phases, full rate tail
// predicts drive requests from its own copy of registers and state, or takes typed ones from the directed
// table; depends on lfpd_pkg and line_follow_pid_drive
`timescale 1ns / 1ps

module line_follow_pid_drive_tb;
	import lfpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int RAND_ITEMS = 1750;
	localparam int FULL_ITEMS = 200;
	localparam int DIR_ROWS = 36;
	localparam longint SUM_HI = 16777215;
	localparam longint SUM_LO = -16777216;

	// indexes that decode to no register
	localparam logic [CIDX_W-1:0] REG_NONE_LO = 4'd8;
	localparam logic [CIDX_W-1:0] REG_NONE_HI = 4'd15;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [CIDX_W-1:0]  reg_idx;
		logic [CDATA_W-1:0] reg_data;
		sample_t            smp;
		logic               typed;
		drive_t             want;
	} dir_row_t;

	// directed rows; drive values are given where they follow directly from the setup
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// zero tick budget: finished before the first tick, state untouched
		'{ROW_WRITE,  REG_TICKS,   24'd0,        '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd1023}, 1'b1, '{10'd0, 10'd0, 1'b1}},
		// writes before the first tick also load last position and base drive
		'{ROW_WRITE,  REG_CENTER,  24'd600,      '0,              1'b0, '0},
		'{ROW_WRITE,  REG_START,   24'd650,      '0,              1'b0, '0},
		'{ROW_WRITE,  REG_TICKS,   24'hFFFFFF,   '0,              1'b0, '0},
		// lost line reuses the loaded center; start above ceiling holds
		'{ROW_SAMPLE, '0,          '0,           '{1'b0, 10'd0},    1'b1, '{10'd650, 10'd650, 1'b0}},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd600},  1'b1, '{10'd650, 10'd650, 1'b0}},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd1023}, 1'b1, '{10'd650, 10'd0, 1'b0}},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd0},    1'b1, '{10'd0, 10'd650, 1'b0}},
		'{ROW_SAMPLE, '0,          '0,           '{1'b0, 10'd1023}, 1'b1, '{10'd0, 10'd650, 1'b0}},
		// all gains zero: no correction
		'{ROW_WRITE,  REG_GAIN_P,  24'd0,        '0,              1'b0, '0},
		'{ROW_WRITE,  REG_GAIN_I,  24'd0,        '0,              1'b0, '0},
		'{ROW_WRITE,  REG_GAIN_D,  24'd0,        '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd1023}, 1'b1, '{10'd650, 10'd650, 1'b0}},
		// start write after the first tick leaves base alone; ramp overshoot is capped
		'{ROW_WRITE,  REG_START,   24'd5,        '0,              1'b0, '0},
		'{ROW_WRITE,  REG_MAX,     24'd700,      '0,              1'b0, '0},
		'{ROW_WRITE,  REG_STEP,    24'd100,      '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd0},    1'b1, '{10'd650, 10'd650, 1'b0}},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd0},    1'b1, '{10'd700, 10'd700, 1'b0}},
		// full scale gains
		'{ROW_WRITE,  REG_GAIN_I,  24'hFFFFFF,   '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd1023}, 1'b0, '0},
		'{ROW_WRITE,  REG_GAIN_P,  24'hFFFFFF,   '0,              1'b0, '0},
		'{ROW_WRITE,  REG_GAIN_D,  24'hFFFFFF,   '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd0},    1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd1023}, 1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b0, 10'd512},  1'b0, '0},
		// unmapped indexes do nothing
		'{ROW_WRITE,  REG_NONE_LO, 24'hFFFFFF,   '0,              1'b0, '0},
		'{ROW_WRITE,  REG_NONE_HI, 24'd0,        '0,              1'b0, '0},
		// center extremes, upper data bits ignored
		'{ROW_WRITE,  REG_CENTER,  24'hFFFC00,   '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd1023}, 1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd0},    1'b0, '0},
		'{ROW_WRITE,  REG_CENTER,  24'hFFFFFF,   '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd0},    1'b0, '0},
		// tick budget below the tick count: run finished
		'{ROW_WRITE,  REG_TICKS,   24'd0,        '0,              1'b0, '0},
		'{ROW_SAMPLE, '0,          '0,           '{1'b1, 10'd512},  1'b1, '{10'd0, 10'd0, 1'b1}},
		'{ROW_WRITE,  REG_TICKS,   24'hFFFFFF,   '0,              1'b0, '0}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               sample_valid = 1'b0;
	logic               sample_stall;
	sample_t            sample = '0;
	logic               drive_valid;
	logic               drive_stall = 1'b0;
	drive_t             drive;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index = '0;
	logic [CDATA_W-1:0] cfg_data = '0;

	// register copy
	logic [POS_W-1:0]  rg_center = CENTER_RST;
	logic [GAIN_W-1:0] rg_gain_p = GAIN_P_RST;
	logic [GAIN_W-1:0] rg_gain_i = GAIN_I_RST;
	logic [GAIN_W-1:0] rg_gain_d = GAIN_D_RST;
	logic [PWM_W-1:0]  rg_start  = START_RST;
	logic [PWM_W-1:0]  rg_max    = MAX_RST;
	logic [STEP_W-1:0] rg_step   = STEP_RST;
	logic [TICK_W-1:0] rg_ticks  = TICKS_RST;

	// steering state copy
	logic [POS_W-1:0]        st_last_pos = CENTER_RST;
	logic signed [ERR_W-1:0] st_last_err = '0;
	logic signed [SUM_W-1:0] st_err_sum  = '0;
	logic [PWM_W-1:0]        st_base     = START_RST;
	logic [TICK_W-1:0]       st_tick     = '0;

	drive_t      drive_q [$];
	int          mismatch_cnt = 0;
	int          rand_sent = 0;
	int          track_pos = 0;
	int unsigned gap_odds = 0;
	int unsigned stall_odds = 0;
	int unsigned stall_left = 0;
	int unsigned cyc_cnt = 0;

	line_follow_pid_drive u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.drive        (drive),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// register write as the block sees it
	function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		case (idx)
			REG_CENTER: begin
				rg_center = data[POS_W-1:0];
				if (st_tick == '0)
					st_last_pos = rg_center;
			end
			REG_GAIN_P: rg_gain_p = data[GAIN_W-1:0];
			REG_GAIN_I: rg_gain_i = data[GAIN_W-1:0];
			REG_GAIN_D: rg_gain_d = data[GAIN_W-1:0];
			REG_START: begin
				rg_start = data[PWM_W-1:0];
				if (st_tick == '0)
					st_base = rg_start;
			end
			REG_MAX:    rg_max   = data[PWM_W-1:0];
			REG_STEP:   rg_step  = data[STEP_W-1:0];
			REG_TICKS:  rg_ticks = data[TICK_W-1:0];
			default: ;
		endcase
	endfunction

	// one control tick: pid correction, clamp, steer, ramp, or run_done once the tick budget is used
	function automatic drive_t predict_drive(sample_t smp);
		drive_t           res;
		logic [POS_W-1:0] pos;
		int               err;
		int               nxt;
		longint           sum, acc, corr, base, lft, rgt;
		res = '0;
		if (st_tick >= rg_ticks) begin
			res.run_done = 1'b1;
			return res;
		end
		pos = smp.line_seen ? smp.position : st_last_pos;
		st_last_pos = pos;
		err = int'({1'b0, pos}) - int'({1'b0, rg_center});

		// integral saturates at the 25 bit range
		sum = longint'(st_err_sum) + err;
		if (sum > SUM_HI)
			sum = SUM_HI;
		if (sum < SUM_LO)
			sum = SUM_LO;
		st_err_sum = sum[SUM_W-1:0];

		acc = longint'(err) * longint'({1'b0, rg_gain_p})
			+ sum * longint'({1'b0, rg_gain_i})
			+ (longint'(err) - longint'(st_last_err)) * longint'({1'b0, rg_gain_d});
		corr = acc >>> 16;
		st_last_err = err[ERR_W-1:0];

		base = longint'({1'b0, st_base});
		if (corr > base)
			corr = base;
		if (corr < -base)
			corr = -base;
		if (corr < 0) begin
			lft = base + corr;
			rgt = base;
		end else begin
			lft = base;
			rgt = base - corr;
		end
		res.left_drive  = lft[PWM_W-1:0];
		res.right_drive = rgt[PWM_W-1:0];

		st_tick = st_tick + 1'b1;
		if (st_base < rg_max) begin
			nxt = int'({1'b0, st_base}) + int'({1'b0, rg_step});
			if (nxt > int'({1'b0, rg_max}))
				nxt = int'({1'b0, rg_max});
			st_base = nxt[PWM_W-1:0];
		end
		return res;
	endfunction

	// offer one sample request, hold it until taken
	task automatic drive_sample(sample_t smp, logic typed, drive_t want);
		drive_t pred;
		sample_valid <= 1'b1;
		sample       <= smp;
		cfg_valid    <= 1'b0;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		pred = predict_drive(smp);
		drive_q.push_back(typed ? want : pred);
	endtask

	// sender gap burst
	task automatic idle_gap();
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			sample_valid <= 1'b0;
			cfg_valid    <= 1'b0;
			repeat ($urandom_range(1, 9))
				@(posedge clk);
		end
	endtask

	// register write once every drive request is out
	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
		sample_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, data);
	endtask

	function automatic logic [CDATA_W-1:0] pick_gain(int bits);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CDATA_W'($urandom_range(0, 1 << bits));
		endcase
	endfunction

	function automatic int unsigned pick_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			2: return 6;
			default: return 12;
		endcase
	endfunction

	// new register setting and idle pattern for a random phase
	task automatic setup_phase();
		logic [CDATA_W-1:0] d;
		if ($urandom_range(0, 1)) begin
			d = CDATA_W'($urandom);
			case ($urandom_range(0, 3))
				0: d[POS_W-1:0] = '0;
				1: d[POS_W-1:0] = '1;
				default: d[POS_W-1:0] = POS_W'($urandom_range(150, 870));
			endcase
			write_reg(REG_CENTER, d);
		end
		if ($urandom_range(0, 1))
			write_reg(REG_GAIN_P, pick_gain(21));
		if ($urandom_range(0, 1))
			write_reg(REG_GAIN_I, pick_gain(13));
		if ($urandom_range(0, 1))
			write_reg(REG_GAIN_D, pick_gain(23));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_START, CDATA_W'($urandom));
		if ($urandom_range(0, 1)) begin
			d = CDATA_W'($urandom);
			case ($urandom_range(0, 3))
				0: d[PWM_W-1:0] = '0;
				1: d[PWM_W-1:0] = 10'd1000;
				2: d[PWM_W-1:0] = '1;
				default: d[PWM_W-1:0] = PWM_W'($urandom_range(0, 1023));
			endcase
			write_reg(REG_MAX, d);
		end
		if ($urandom_range(0, 1)) begin
			d = CDATA_W'($urandom);
			case ($urandom_range(0, 3))
				0: d[STEP_W-1:0] = '0;
				1: d[STEP_W-1:0] = 7'd100;
				2: d[STEP_W-1:0] = '1;
				default: d[STEP_W-1:0] = STEP_W'($urandom_range(0, 3));
			endcase
			write_reg(REG_STEP, d);
		end
		// mostly a long budget, sometimes one that runs out within the phase
		d = CDATA_W'($urandom);
		if ($urandom_range(0, 3) == 0)
			d[TICK_W-1:0] = st_tick + TICK_W'($urandom_range(5, 60));
		else
			d[TICK_W-1:0] = '1;
		write_reg(REG_TICKS, d);
		if ($urandom_range(0, 5) == 0)
			write_reg(CIDX_W'($urandom_range(REG_NONE_LO, REG_NONE_HI)), CDATA_W'($urandom));
		gap_odds   = pick_odds();
		stall_odds = pick_odds();
		track_pos  = int'({1'b0, rg_center});
	endtask

	// mostly a line drifting around center, some lost line and some noise
	task automatic send_random_item();
		sample_t smp;
		int      pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			track_pos = track_pos + int'($urandom_range(0, 80)) - 40;
			if (track_pos < 0)
				track_pos = 0;
			if (track_pos > 1023)
				track_pos = 1023;
			smp.line_seen = 1'b1;
			smp.position  = track_pos[POS_W-1:0];
		end else begin
			smp.line_seen = (pick >= 85);
			smp.position  = POS_W'($urandom_range(0, 1023));
		end
		idle_gap();
		drive_sample(smp, 1'b0, '0);
	endtask

	// receiver stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			drive_stall <= 1'b1;
			stall_left  <= stall_left - 1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			drive_stall <= 1'b1;
			stall_left  <= $urandom_range(0, 8);
		end else begin
			drive_stall <= 1'b0;
		end
	end

	// compare each drive request with the oldest expected one
	always @(posedge clk) begin : drive_check
		drive_t want;
		if (arst_n && drive_valid && !drive_stall) begin
			if (drive_q.size() == 0) begin
				$error("drive request with nothing expected: %p", drive);
				mismatch_cnt++;
			end else begin
				want = drive_q.pop_front();
				if (drive.left_drive !== want.left_drive) begin
					$error("left_drive expected %0d got %0d", want.left_drive,
						drive.left_drive);
					mismatch_cnt++;
				end
				if (drive.right_drive !== want.right_drive) begin
					$error("right_drive expected %0d got %0d", want.right_drive,
						drive.right_drive);
					mismatch_cnt++;
				end
				if (drive.run_done !== want.run_done) begin
					$error("run_done expected %0d got %0d", want.run_done, drive.run_done);
					mismatch_cnt++;
				end
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t row;
		int       n;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		gap_odds   = 4;
		stall_odds = 4;
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TAB[i];
			if (row.kind == ROW_WRITE) begin
				write_reg(row.reg_idx, row.reg_data);
			end else begin
				idle_gap();
				drive_sample(row.smp, row.typed, row.want);
			end
		end

		// random phases
		while (rand_sent < RAND_ITEMS) begin
			setup_phase();
			n = $urandom_range(80, 240);
			while (n > 0 && rand_sent < RAND_ITEMS) begin
				send_random_item();
				rand_sent++;
				n--;
			end
		end

		// full rate to the end, no idling on either side
		gap_odds   = 0;
		stall_odds = 0;
		write_reg(REG_TICKS, 24'hFFFFFF);
		write_reg(REG_GAIN_I, CDATA_W'($urandom_range(0, 4096)));
		track_pos = int'({1'b0, rg_center});
		repeat (FULL_ITEMS)
			send_random_item();

		// drain
		sample_valid <= 1'b0;
		cfg_valid    <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> line_follow_pid_drive.f
rtl/core/lfpd_pkg.sv
rtl/core/line_follow_pid_drive.sv
tb/line_follow_pid_drive_tb.sv
